[hdl/mvcctt_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// MVCC transaction table package
// Operation, status and state codes, controller states and the command and
// status bundles shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package mvcctt_pkg;

  typedef enum logic [2:0] {
    KIND_BEGIN       = 3'd0,
    KIND_COMMIT      = 3'd1,
    KIND_ROLLBACK    = 3'd2,
    KIND_MARK_FAILED = 3'd3,
    KIND_QUERY       = 3'd4,
    KIND_PRUNE       = 3'd5,
    KIND_ALLOC_TS    = 3'd6,
    KIND_BOOTSTRAP   = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_NOT_FOUND   = 2'd1,
    STAT_WRONG_STATE = 2'd2,
    STAT_FULL        = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    TXN_ACTIVE    = 2'd0,
    TXN_FAILED    = 2'd1,
    TXN_COMMITTED = 2'd2
  } txn_state_t;

  localparam logic CFG_FIRST_TXN_ID    = 1'b0;
  localparam logic CFG_FIRST_TIMESTAMP = 1'b1;

  localparam logic [63:0] RESET_TXN_ID    = 64'd1;
  localparam logic [63:0] RESET_TIMESTAMP = 64'd1;

  localparam int TOTAL_W = 5;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RUN_A,
    S_WAIT_A,
    S_RUN_D,
    S_WAIT_D,
    S_EXEC,
    S_RUN_W,
    S_WAIT_W,
    S_FINISH
  } ctl_state_t;

  typedef enum logic {
    TBL_ACTIVE = 1'b0,
    TBL_DONE   = 1'b1
  } tbl_t;

  typedef struct packed {
    logic capture;
    logic scan_start;
    tbl_t scan_tbl;
    logic exec;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_busy;
  } dp_sts_t;

endpackage
`default_nettype wire

[hdl/mvcctt_ifs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// MVCC transaction table channels
// Valid/ready channels for operation items and result items.
// ----------------------------------------------------------------------------
interface mvcctt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [63:0] txn_id;
  logic [63:0] ts_floor;

  modport source(output valid, output kind, output txn_id, output ts_floor, input ready);
  modport sink(input valid, input kind, input txn_id, input ts_floor, output ready);
endinterface

interface mvcctt_out_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       status;
  logic [63:0]                      txn_id_out;
  logic [63:0]                      timestamp;
  logic [63:0]                      commit_stamp;
  logic [1:0]                       txn_state;
  logic [mvcctt_pkg::TOTAL_W-1:0]   active_total;
  logic [63:0]                      watermark;

  modport source(output valid, output status, output txn_id_out, output timestamp,
                 output commit_stamp, output txn_state, output active_total,
                 output watermark, input ready);
  modport sink(input valid, input status, input txn_id_out, input timestamp,
               input commit_stamp, input txn_state, input active_total,
               input watermark, output ready);
endinterface
`default_nettype wire

[hdl/mvcctt_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// MVCC transaction table controller
// Sequences capture, table scans, execution and result hand-off.
// ----------------------------------------------------------------------------
module mvcctt_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output mvcctt_pkg::dp_cmd_t      cmd,
  input  wire mvcctt_pkg::dp_sts_t sts
);

  mvcctt_pkg::ctl_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mvcctt_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    in_ready       = 1'b0;
    cmd.capture    = 1'b0;
    cmd.scan_start = 1'b0;
    cmd.scan_tbl   = mvcctt_pkg::TBL_ACTIVE;
    cmd.exec       = 1'b0;
    cmd.load_out   = 1'b0;
    case (state_r)
      mvcctt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = mvcctt_pkg::S_RUN_A;
        end
      end
      mvcctt_pkg::S_RUN_A: begin
        cmd.scan_start = 1'b1;
        state_nxt      = mvcctt_pkg::S_WAIT_A;
      end
      mvcctt_pkg::S_WAIT_A: begin
        if (!sts.scan_busy) state_nxt = mvcctt_pkg::S_RUN_D;
      end
      mvcctt_pkg::S_RUN_D: begin
        cmd.scan_start = 1'b1;
        cmd.scan_tbl   = mvcctt_pkg::TBL_DONE;
        state_nxt      = mvcctt_pkg::S_WAIT_D;
      end
      mvcctt_pkg::S_WAIT_D: begin
        if (!sts.scan_busy) state_nxt = mvcctt_pkg::S_EXEC;
      end
      mvcctt_pkg::S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = mvcctt_pkg::S_RUN_W;
      end
      mvcctt_pkg::S_RUN_W: begin
        cmd.scan_start = 1'b1;
        state_nxt      = mvcctt_pkg::S_WAIT_W;
      end
      mvcctt_pkg::S_WAIT_W: begin
        if (!sts.scan_busy) state_nxt = mvcctt_pkg::S_FINISH;
      end
      mvcctt_pkg::S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = mvcctt_pkg::S_IDLE;
        end
      end
      default: state_nxt = mvcctt_pkg::S_IDLE;
    endcase
    out_valid_nxt = cmd.load_out | (out_valid_r & ~out_ready);
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

[hdl/mvcctt_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// MVCC transaction table datapath
// Table memories, scan engine, counters, operation execution and result
// registers.
// ----------------------------------------------------------------------------
module mvcctt_datapath #(
  parameter int ACTIVE_ENTRIES = 16,
  parameter int DONE_ENTRIES   = 32,
  parameter int CNT_W          = 5
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire mvcctt_pkg::dp_cmd_t    cmd,
  output mvcctt_pkg::dp_sts_t         sts,
  input  wire logic [2:0]             in_kind,
  input  wire logic [63:0]            in_txn_id,
  input  wire logic [63:0]            in_ts_floor,
  input  wire logic                   cfg_we,
  input  wire logic [0:0]             cfg_index,
  input  wire logic [63:0]            cfg_data,
  output logic [1:0]                  out_status,
  output logic [63:0]                 out_txn_id_out,
  output logic [63:0]                 out_timestamp,
  output logic [63:0]                 out_commit_stamp,
  output logic [1:0]                  out_txn_state,
  output logic [mvcctt_pkg::TOTAL_W-1:0] out_active_total,
  output logic [63:0]                 out_watermark
);

  localparam int AW = (ACTIVE_ENTRIES > 1) ? $clog2(ACTIVE_ENTRIES) : 1;
  localparam int DW = (DONE_ENTRIES > 1) ? $clog2(DONE_ENTRIES) : 1;
  localparam int SW = ((AW > DW) ? AW : DW) + 1;
  localparam int TW = mvcctt_pkg::TOTAL_W;

  // Captured item and counters.
  mvcctt_pkg::kind_t kind_r;
  logic [63:0] id_r, bound_r;
  logic [63:0] next_id_r, next_id_nxt, next_stamp_r, next_stamp_nxt;

  // Tables.
  logic        act_valid_r [ACTIVE_ENTRIES];
  logic [63:0] act_id_r    [ACTIVE_ENTRIES];
  logic [63:0] act_ts_r    [ACTIVE_ENTRIES];
  logic        act_fail_r  [ACTIVE_ENTRIES];
  logic        done_valid_r[DONE_ENTRIES];
  logic [63:0] done_id_r   [DONE_ENTRIES];
  logic [63:0] done_rts_r  [DONE_ENTRIES];
  logic [63:0] done_cts_r  [DONE_ENTRIES];

  // Scan engine.
  logic              run_r, pv_r, vq_r;
  mvcctt_pkg::tbl_t  tbl_r;
  logic [SW-1:0]     idx_r, pidx_r, last_idx;
  logic [AW-1:0]     a_addr;
  logic [DW-1:0]     d_addr;
  logic [63:0]       rd_aid_r, rd_ats_r, rd_did_r, rd_drts_r, rd_dcts_r;
  logic              rd_afail_r;
  logic              proc_a, proc_d;

  // Scan results.
  logic              fa_r, fa_fail_r, ffa_r, any_r, fd_r, ffd_r;
  logic [AW-1:0]     fa_idx_r, ffa_idx_r;
  logic [63:0]       fa_ts_r, min_r, fd_rts_r, fd_cts_r;
  logic [DW-1:0]     fd_idx_r, ffd_idx_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [63:0]       wm;

  // Execution.
  mvcctt_pkg::status_t    res_status_nxt, res_status_r;
  mvcctt_pkg::txn_state_t res_st_nxt, res_st_r;
  logic [63:0] res_id_nxt, res_id_r, res_ts_nxt, res_ts_r, res_cts_nxt, res_cts_r;
  logic        a_wr, a_fail_wr, a_clr, d_wr;
  logic [DW-1:0] d_wr_idx;

  assign a_addr   = idx_r[AW-1:0];
  assign d_addr   = idx_r[DW-1:0];
  assign last_idx = (tbl_r == mvcctt_pkg::TBL_ACTIVE) ? SW'(ACTIVE_ENTRIES - 1)
                                                       : SW'(DONE_ENTRIES - 1);
  assign proc_a   = pv_r && (tbl_r == mvcctt_pkg::TBL_ACTIVE);
  assign proc_d   = pv_r && (tbl_r == mvcctt_pkg::TBL_DONE);
  assign sts.scan_busy = run_r | pv_r;
  assign wm = any_r ? min_r : next_stamp_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r  <= mvcctt_pkg::kind_t'(in_kind);
      id_r    <= in_txn_id;
      bound_r <= in_ts_floor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      pv_r  <= 1'b0;
      tbl_r <= mvcctt_pkg::TBL_ACTIVE;
      idx_r <= '0;
    end else begin
      pv_r <= run_r;
      if (cmd.scan_start) begin
        run_r <= 1'b1;
        idx_r <= '0;
        tbl_r <= cmd.scan_tbl;
      end else if (run_r) begin
        if (idx_r == last_idx) begin
          run_r <= 1'b0;
        end else begin
          idx_r <= idx_r + SW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pidx_r     <= idx_r;
    vq_r       <= (tbl_r == mvcctt_pkg::TBL_ACTIVE) ? act_valid_r[a_addr]
                                                     : done_valid_r[d_addr];
    rd_aid_r   <= act_id_r[a_addr];
    rd_ats_r   <= act_ts_r[a_addr];
    rd_afail_r <= act_fail_r[a_addr];
    rd_did_r   <= done_id_r[d_addr];
    rd_drts_r  <= done_rts_r[d_addr];
    rd_dcts_r  <= done_cts_r[d_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fa_r  <= 1'b0;
      ffa_r <= 1'b0;
      any_r <= 1'b0;
      fd_r  <= 1'b0;
      ffd_r <= 1'b0;
      cnt_r <= '0;
    end else if (cmd.scan_start && cmd.scan_tbl == mvcctt_pkg::TBL_ACTIVE) begin
      fa_r  <= 1'b0;
      ffa_r <= 1'b0;
      any_r <= 1'b0;
      cnt_r <= '0;
    end else if (cmd.scan_start) begin
      fd_r  <= 1'b0;
      ffd_r <= 1'b0;
    end else if (proc_a) begin
      if (vq_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (rd_aid_r == id_r && !fa_r) begin
          fa_r      <= 1'b1;
          fa_idx_r  <= pidx_r[AW-1:0];
          fa_ts_r   <= rd_ats_r;
          fa_fail_r <= rd_afail_r;
        end
        if (!any_r || rd_ats_r < min_r) begin
          any_r <= 1'b1;
          min_r <= rd_ats_r;
        end
      end else if (!ffa_r) begin
        ffa_r     <= 1'b1;
        ffa_idx_r <= pidx_r[AW-1:0];
      end
    end else if (proc_d) begin
      if (vq_r) begin
        if (rd_did_r == id_r && !fd_r) begin
          fd_r     <= 1'b1;
          fd_idx_r <= pidx_r[DW-1:0];
          fd_rts_r <= rd_drts_r;
          fd_cts_r <= rd_dcts_r;
        end
      end else if (!ffd_r) begin
        ffd_r     <= 1'b1;
        ffd_idx_r <= pidx_r[DW-1:0];
      end
    end
  end

  always_comb begin
    res_status_nxt = mvcctt_pkg::STAT_OK;
    res_id_nxt     = id_r;
    res_ts_nxt     = '0;
    res_cts_nxt    = '0;
    res_st_nxt     = mvcctt_pkg::TXN_ACTIVE;
    next_id_nxt    = next_id_r;
    next_stamp_nxt = next_stamp_r;
    a_wr           = 1'b0;
    a_fail_wr      = 1'b0;
    a_clr          = 1'b0;
    d_wr           = 1'b0;
    d_wr_idx       = fd_r ? fd_idx_r : ffd_idx_r;
    case (kind_r)
      mvcctt_pkg::KIND_BEGIN: begin
        if (!ffa_r) begin
          res_status_nxt = mvcctt_pkg::STAT_FULL;
          res_id_nxt     = '0;
        end else begin
          res_id_nxt     = next_id_r;
          res_ts_nxt     = next_stamp_r;
          next_id_nxt    = next_id_r + 64'd1;
          next_stamp_nxt = next_stamp_r + 64'd1;
          a_wr           = 1'b1;
        end
      end
      mvcctt_pkg::KIND_COMMIT: begin
        if (!fa_r) begin
          res_status_nxt = mvcctt_pkg::STAT_NOT_FOUND;
        end else if (fa_fail_r) begin
          res_status_nxt = mvcctt_pkg::STAT_WRONG_STATE;
        end else if (!fd_r && !ffd_r) begin
          res_status_nxt = mvcctt_pkg::STAT_FULL;
        end else begin
          res_ts_nxt     = next_stamp_r;
          next_stamp_nxt = next_stamp_r + 64'd1;
          d_wr           = 1'b1;
          a_clr          = 1'b1;
        end
      end
      mvcctt_pkg::KIND_ROLLBACK: begin
        if (!fa_r) begin
          res_status_nxt = mvcctt_pkg::STAT_NOT_FOUND;
        end else begin
          a_clr = 1'b1;
        end
      end
      mvcctt_pkg::KIND_MARK_FAILED: begin
        if (!fa_r) begin
          res_status_nxt = mvcctt_pkg::STAT_NOT_FOUND;
        end else if (fa_fail_r) begin
          res_status_nxt = mvcctt_pkg::STAT_WRONG_STATE;
        end else begin
          a_fail_wr = 1'b1;
        end
      end
      mvcctt_pkg::KIND_QUERY: begin
        if (fa_r) begin
          res_ts_nxt = fa_ts_r;
          res_st_nxt = fa_fail_r ? mvcctt_pkg::TXN_FAILED : mvcctt_pkg::TXN_ACTIVE;
        end else if (fd_r) begin
          res_ts_nxt  = fd_rts_r;
          res_cts_nxt = fd_cts_r;
          res_st_nxt  = mvcctt_pkg::TXN_COMMITTED;
        end else begin
          res_status_nxt = mvcctt_pkg::STAT_NOT_FOUND;
        end
      end
      mvcctt_pkg::KIND_PRUNE: begin
        res_ts_nxt = '0;
      end
      mvcctt_pkg::KIND_ALLOC_TS: begin
        res_ts_nxt     = next_stamp_r;
        next_stamp_nxt = next_stamp_r + 64'd1;
      end
      mvcctt_pkg::KIND_BOOTSTRAP: begin
        next_stamp_nxt = (next_stamp_r < bound_r) ? bound_r : next_stamp_r;
        res_ts_nxt     = next_stamp_nxt;
      end
      default: res_ts_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && a_wr) begin
      act_id_r[ffa_idx_r]   <= next_id_r;
      act_ts_r[ffa_idx_r]   <= next_stamp_r;
      act_fail_r[ffa_idx_r] <= 1'b0;
    end else if (cmd.exec && a_fail_wr) begin
      act_fail_r[fa_idx_r] <= 1'b1;
    end
    if (cmd.exec && d_wr) begin
      done_id_r[d_wr_idx]  <= id_r;
      done_rts_r[d_wr_idx] <= fa_ts_r;
      done_cts_r[d_wr_idx] <= next_stamp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ACTIVE_ENTRIES; i++) act_valid_r[i] <= 1'b0;
      for (int j = 0; j < DONE_ENTRIES; j++) done_valid_r[j] <= 1'b0;
    end else begin
      if (cmd.exec && a_wr) act_valid_r[ffa_idx_r] <= 1'b1;
      if (cmd.exec && a_clr) act_valid_r[fa_idx_r] <= 1'b0;
      if (cmd.exec && d_wr) done_valid_r[d_wr_idx] <= 1'b1;
      if (proc_d && vq_r && kind_r == mvcctt_pkg::KIND_PRUNE && rd_dcts_r < wm) begin
        done_valid_r[pidx_r[DW-1:0]] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_id_r    <= mvcctt_pkg::RESET_TXN_ID;
      next_stamp_r <= mvcctt_pkg::RESET_TIMESTAMP;
    end else if (cfg_we) begin
      if (cfg_index == mvcctt_pkg::CFG_FIRST_TXN_ID) begin
        next_id_r <= cfg_data;
      end else begin
        next_stamp_r <= cfg_data;
      end
    end else if (cmd.exec) begin
      next_id_r    <= next_id_nxt;
      next_stamp_r <= next_stamp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status_r <= res_status_nxt;
      res_id_r     <= res_id_nxt;
      res_ts_r     <= res_ts_nxt;
      res_cts_r    <= res_cts_nxt;
      res_st_r     <= res_st_nxt;
    end
    if (cmd.load_out) begin
      out_status       <= res_status_r;
      out_txn_id_out   <= res_id_r;
      out_timestamp    <= res_ts_r;
      out_commit_stamp <= res_cts_r;
      out_txn_state    <= res_st_r;
      out_active_total <= TW'(cnt_r);
      out_watermark    <= wm;
    end
  end

endmodule
`default_nettype wire

[hdl/mvcc_transaction_table.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// MVCC transaction table
// Active and committed transaction tables with id and timestamp counters.
//
//   Channel  Direction  Contents
//   in_ch    sink       kind, txn_id, ts_floor
//   out_ch   source     status, txn_id_out, timestamp, commit_stamp,
//                       txn_state, active_total, watermark
//   cfg_*    write      first_txn_id (index 0), first_timestamp (index 1)
//
// Each item is worked through by the scan engine, which reads the active table,
// then the committed table, then the active table again, one entry per cycle.
// One item is in work at a time; a finished result waits in the output register
// while the next item is accepted. Reset is synchronous.
// ----------------------------------------------------------------------------
module mvcc_transaction_table #(
  parameter int ACTIVE_ENTRIES = 16,
  parameter int DONE_ENTRIES   = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  mvcctt_in_if.sink        in_ch,
  mvcctt_out_if.source     out_ch,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  localparam int CNT_W = $clog2(ACTIVE_ENTRIES + 1);

  mvcctt_pkg::dp_cmd_t cmd;
  mvcctt_pkg::dp_sts_t sts;

  mvcctt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  mvcctt_datapath #(
    .ACTIVE_ENTRIES (ACTIVE_ENTRIES),
    .DONE_ENTRIES   (DONE_ENTRIES),
    .CNT_W          (CNT_W)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_kind          (in_ch.kind),
    .in_txn_id        (in_ch.txn_id),
    .in_ts_floor      (in_ch.ts_floor),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_status       (out_ch.status),
    .out_txn_id_out   (out_ch.txn_id_out),
    .out_timestamp    (out_ch.timestamp),
    .out_commit_stamp (out_ch.commit_stamp),
    .out_txn_state    (out_ch.txn_state),
    .out_active_total (out_ch.active_total),
    .out_watermark    (out_ch.watermark)
  );

endmodule
`default_nettype wire
